// ===== design/audio_loop_recorder_multi_head_assert.svh =====
// assertion macros shared by the loop recorder modules
`ifndef AUDIO_LOOP_RECORDER_MULTI_HEAD_ASSERT_SVH
`define AUDIO_LOOP_RECORDER_MULTI_HEAD_ASSERT_SVH
`ifndef SYNTHESIS
`define ALR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);
`define ALR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define ALR_ASSERT(lbl, clk, rst_n, prop, msg)
`define ALR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/alr_pkg.sv =====
// shared constants and types of the loop recorder
`default_nettype none
package alr_pkg;
  localparam int unsigned STORE_DEPTH_DEF = 262144;
  localparam int unsigned HEAD_COUNT_DEF  = 16;
  localparam int unsigned SAMPLE_BITS_DEF = 24;

  localparam int unsigned DEV_BITS       = 8;
  localparam int unsigned KEY_BITS       = 8;
  localparam int unsigned ACTION_BITS    = 2;
  localparam int unsigned LENGTH_BITS    = 19;
  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS  = 19;

  // tdata layout: device, key, period flag, then the sample
  localparam int unsigned DEV_LSB    = 0;
  localparam int unsigned KEY_LSB    = DEV_LSB + DEV_BITS;
  localparam int unsigned HIT_BIT    = KEY_LSB + KEY_BITS;
  localparam int unsigned SAMPLE_LSB = HIT_BIT + 1;

  localparam logic [LENGTH_BITS-1:0] MAX_LENGTH_RST = 19'd262144;

  localparam logic [ACTION_BITS-1:0] ACT_POS    = 2'd1;
  localparam logic [ACTION_BITS-1:0] ACT_NONPOS = 2'd2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_DEVICE     = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KEY        = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_LENGTH = 2'd2;

  localparam int unsigned KIND_BITS   = 2;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_NONE,
    KIND_PRESS,
    KIND_RELEASE,
    KIND_HIT
  } alr_kind_e;

  function automatic int unsigned bytes_up(input int unsigned bits);
    return ((bits + 7) >> 3) << 3;
  endfunction
endpackage
`default_nettype wire

// ===== design/alr_front.sv =====
// front end: takes an item and classifies its record event
`default_nettype none
module alr_front #(
  parameter int unsigned SAMPLE_BITS = alr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               valid_i,
  output logic                               ready_o,
  input  logic [alr_pkg::ACTION_BITS-1:0]    action_i,
  input  logic [alr_pkg::DEV_BITS-1:0]       device_i,
  input  logic [alr_pkg::KEY_BITS-1:0]       key_i,
  input  logic                               hit_i,
  input  logic [SAMPLE_BITS-1:0]             sample_i,
  input  logic [alr_pkg::DEV_BITS-1:0]       record_device_i,
  input  logic [alr_pkg::KEY_BITS-1:0]       record_key_i,
  input  logic                               full_i,
  output logic                               push_o,
  output logic [alr_pkg::KIND_BITS+SAMPLE_BITS-1:0] entry_o
);
  import alr_pkg::*;

  logic      matched;
  alr_kind_e kind;

  assign matched = (action_i == ACT_POS || action_i == ACT_NONPOS) &&
                   device_i == record_device_i && key_i == record_key_i;

  always_comb begin
    if (matched) begin
      kind = (action_i == ACT_POS) ? KIND_PRESS : KIND_RELEASE;
    end else if (hit_i) begin
      kind = KIND_HIT;
    end else begin
      kind = KIND_NONE;
    end
  end

  assign ready_o = !full_i;
  assign push_o  = valid_i && !full_i;
  assign entry_o = {kind, sample_i};
endmodule
`default_nettype wire

// ===== design/alr_queue.sv =====
// short fifo between the front end and the back end
`default_nettype none
`include "audio_loop_recorder_multi_head_assert.svh"
module alr_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = alr_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [NW-1:0]    count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == NW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `ALR_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= NW'(DEPTH), "queue count over depth")
endmodule
`default_nettype wire

// ===== design/alr_back.sv =====
// back end: recording, playback head walk over the loop store, saturated mix
`default_nettype none
`include "audio_loop_recorder_multi_head_assert.svh"
module alr_back #(
  parameter int unsigned STORE_DEPTH = alr_pkg::STORE_DEPTH_DEF,
  parameter int unsigned HEAD_COUNT  = alr_pkg::HEAD_COUNT_DEF,
  parameter int unsigned SAMPLE_BITS = alr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   empty_i,
  input  logic [alr_pkg::KIND_BITS+SAMPLE_BITS-1:0] entry_i,
  output logic                                   pop_o,
  input  logic [alr_pkg::LENGTH_BITS-1:0]        max_length_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [SAMPLE_BITS-1:0]                 out_sample_o
);
  import alr_pkg::*;

  localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned LW = (CW > LENGTH_BITS) ? CW : LENGTH_BITS;
  localparam int unsigned HW = (HEAD_COUNT > 1) ? $clog2(HEAD_COUNT) : 1;
  localparam int unsigned JW = $clog2(HEAD_COUNT + 1);
  localparam int unsigned SW = SAMPLE_BITS + $clog2(HEAD_COUNT + 1);

  localparam logic signed [SW-1:0] SAT_HI =
    {{(SW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO =
    {{(SW - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HEAD = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [SAMPLE_BITS-1:0] store_mem [STORE_DEPTH];

  logic [1:0]             state_q, state_d;
  logic                   recording_q, recording_d;
  logic [CW-1:0]          wi_q, wi_d;
  logic [HW-1:0]          newest_q, newest_d;
  logic [CW-1:0]          pos_q [HEAD_COUNT];
  logic [CW-1:0]          pos_d [HEAD_COUNT];
  logic [HEAD_COUNT-1:0]  active_q, active_d;
  logic [JW-1:0]          j_q, j_d;
  logic signed [SW-1:0]   sum_q, sum_d;
  logic                   pend_q, pend_d;
  logic [SAMPLE_BITS-1:0] rd_data_q;
  logic                   out_valid_q, out_valid_d;
  logic [SAMPLE_BITS-1:0] out_sample_q, out_sample_d;

  alr_kind_e              kind;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic [LW-1:0]          len_ext;
  logic [CW-1:0]          limit;

  // item start: event and recording applied on top of the current state
  logic                   st_rec;
  logic [CW-1:0]          st_wi;
  logic [HW-1:0]          st_newest;
  logic [HEAD_COUNT-1:0]  st_active;
  logic                   st_clear_pos;
  logic                   st_set_pos;
  logic                   st_wr;
  logic [AW-1:0]          wr_addr;

  logic [JW:0]            hsum;
  logic [HW-1:0]          h_idx;
  logic                   go;
  logic                   rd_en, wr_en;
  logic [AW-1:0]          rd_addr;

  assign kind      = alr_kind_e'(entry_i[KIND_BITS+SAMPLE_BITS-1:SAMPLE_BITS]);
  assign in_sample = entry_i[SAMPLE_BITS-1:0];
  assign len_ext   = LW'(max_length_i);
  assign limit     = (len_ext > LW'(STORE_DEPTH)) ? CW'(STORE_DEPTH) : CW'(len_ext);

  always_comb begin
    st_rec       = recording_q;
    st_wi        = wi_q;
    st_newest    = newest_q;
    st_active    = active_q;
    st_clear_pos = 1'b0;
    st_set_pos   = 1'b0;
    st_wr        = 1'b0;
    wr_addr      = '0;
    case (kind)
      KIND_PRESS: begin
        st_rec       = 1'b1;
        st_wi        = '0;
        st_newest    = '0;
        st_active    = '0;
        st_clear_pos = 1'b1;
      end
      KIND_RELEASE: begin
        st_rec = 1'b0;
      end
      KIND_HIT: begin
        if (wi_q != '0) begin
          st_newest            = (newest_q == '0) ? HW'(HEAD_COUNT - 1) : newest_q - 1'b1;
          st_active[st_newest] = 1'b1;
          st_set_pos           = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (st_rec) begin
      if (st_wi < limit) begin
        st_wr   = 1'b1;
        wr_addr = st_wi[AW-1:0];
        st_wi   = st_wi + 1'b1;
      end else begin
        st_rec = 1'b0;
      end
    end
  end

  // ring position of the current head, newest first
  assign hsum  = (JW + 1)'(j_q) + (JW + 1)'(newest_q);
  assign h_idx = (hsum >= (JW + 1)'(HEAD_COUNT)) ? HW'(hsum - (JW + 1)'(HEAD_COUNT))
                                                 : HW'(hsum);
  assign go    = (j_q < JW'(HEAD_COUNT)) && active_q[h_idx] && (pos_q[h_idx] < wi_q);

  always_comb begin
    state_d      = state_q;
    recording_d  = recording_q;
    wi_d         = wi_q;
    newest_d     = newest_q;
    pos_d        = pos_q;
    active_d     = active_q;
    j_d          = j_q;
    sum_d        = sum_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q;
    out_sample_d = out_sample_q;
    pop_o        = 1'b0;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    rd_addr      = '0;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o       = 1'b1;
          wr_en       = st_wr;
          recording_d = st_rec;
          wi_d        = st_wi;
          newest_d    = st_newest;
          active_d    = st_active;
          if (st_clear_pos) begin
            for (int i = 0; i < HEAD_COUNT; i++) begin
              pos_d[i] = '0;
            end
          end
          if (st_set_pos) begin
            pos_d[st_newest] = '0;
          end
          sum_d   = SW'($signed(in_sample));
          j_d     = '0;
          pend_d  = 1'b0;
          state_d = ST_HEAD;
        end
      end
      ST_HEAD: begin
        // the read issued last cycle lands now
        sum_d = pend_q ? sum_q + SW'($signed(rd_data_q)) : sum_q;
        if (go) begin
          rd_en        = 1'b1;
          rd_addr      = pos_q[h_idx][AW-1:0];
          pos_d[h_idx] = pos_q[h_idx] + 1'b1;
          j_d          = j_q + 1'b1;
          pend_d       = 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (sum_q > SAT_HI) begin
            out_sample_d = SAT_HI[SAMPLE_BITS-1:0];
          end else if (sum_q < SAT_LO) begin
            out_sample_d = SAT_LO[SAMPLE_BITS-1:0];
          end else begin
            out_sample_d = sum_q[SAMPLE_BITS-1:0];
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[wr_addr] <= in_sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= store_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q        <= sum_d;
    out_sample_q <= out_sample_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      recording_q <= 1'b0;
      wi_q        <= '0;
      newest_q    <= '0;
      pos_q       <= '{default: '0};
      active_q    <= '0;
      j_q         <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      recording_q <= recording_d;
      wi_q        <= wi_d;
      newest_q    <= newest_d;
      pos_q       <= pos_d;
      active_q    <= active_d;
      j_q         <= j_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;

  `ALR_ASSERT(a_wi_bound, clk_i, rst_ni, wi_q <= CW'(STORE_DEPTH), "write index past store")
  `ALR_ASSERT(a_j_bound, clk_i, rst_ni, j_q <= JW'(HEAD_COUNT), "head walk past ring")
  `ALR_ASSERT_IMP(a_newest_live, clk_i, rst_ni, |active_q, active_q[newest_q], "newest head idle")
  `ALR_ASSERT_IMP(a_pend_head, clk_i, rst_ni, pend_q, state_q == ST_HEAD, "read pending off walk")
endmodule
`default_nettype wire

// ===== design/audio_loop_recorder_multi_head.sv =====
// Loop recorder with overlapping playback heads. Each input item carries one
// signed sample, an optional record event (tuser) and the period flag. An item
// enters a two-entry queue at once and is then worked by the back end, one item
// at a time: the idle state applies the event and stores the sample, the head
// state walks the playing heads newest first, and the output state saturates and
// registers the result once the output register is free. The single read port
// of the loop store gives one head read per cycle. The loop store has no reset
// and needs no clearing pass: heads only read entries below the write index.
// Configuration is a plain write port: 0 record device, 1 record key,
// 2 maximum length (clamped to the store depth, zero stops recording at once).
`default_nettype none
module audio_loop_recorder_multi_head #(
  parameter int unsigned STORE_DEPTH = alr_pkg::STORE_DEPTH_DEF,
  parameter int unsigned HEAD_COUNT  = alr_pkg::HEAD_COUNT_DEF,
  parameter int unsigned SAMPLE_BITS = alr_pkg::SAMPLE_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // event_device, event_key, period_hit, sample
  input  logic [alr_pkg::bytes_up(alr_pkg::SAMPLE_LSB + SAMPLE_BITS)-1:0] s_axis_tdata,
  // action
  input  logic [alr_pkg::ACTION_BITS-1:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // mixed_sample
  output logic [alr_pkg::bytes_up(SAMPLE_BITS)-1:0] m_axis_tdata,
  input  logic cfg_we_i,
  input  logic [alr_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [alr_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);
  import alr_pkg::*;

  localparam int unsigned EW = KIND_BITS + SAMPLE_BITS;
  localparam int unsigned OW = bytes_up(SAMPLE_BITS);

  logic [DEV_BITS-1:0]    rec_device_q;
  logic [KEY_BITS-1:0]    rec_key_q;
  logic [LENGTH_BITS-1:0] max_length_q;

  logic                   push, full, empty, pop;
  logic [EW-1:0]          push_entry, head_entry;
  logic [SAMPLE_BITS-1:0] out_sample;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_device_q <= '0;
      rec_key_q    <= '0;
      max_length_q <= MAX_LENGTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_DEVICE:     rec_device_q <= cfg_data_i[DEV_BITS-1:0];
        REG_KEY:        rec_key_q    <= cfg_data_i[KEY_BITS-1:0];
        REG_MAX_LENGTH: max_length_q <= cfg_data_i[LENGTH_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  alr_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .valid_i        (s_axis_tvalid),
    .ready_o        (s_axis_tready),
    .action_i       (s_axis_tuser),
    .device_i       (s_axis_tdata[DEV_LSB +: DEV_BITS]),
    .key_i          (s_axis_tdata[KEY_LSB +: KEY_BITS]),
    .hit_i          (s_axis_tdata[HIT_BIT]),
    .sample_i       (s_axis_tdata[SAMPLE_LSB +: SAMPLE_BITS]),
    .record_device_i(rec_device_q),
    .record_key_i   (rec_key_q),
    .full_i         (full),
    .push_o         (push),
    .entry_o        (push_entry)
  );

  alr_queue #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_entry),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (head_entry)
  );

  alr_back #(
    .STORE_DEPTH(STORE_DEPTH),
    .HEAD_COUNT (HEAD_COUNT),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .entry_i     (head_entry),
    .pop_o       (pop),
    .max_length_i(max_length_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_sample_o(out_sample)
  );

  assign m_axis_tdata = OW'(out_sample);
endmodule
`default_nettype wire
